[sv/ffca_pkg.sv]
// Shared types and constants for the first-fit contiguous block allocator.
// No dependencies; every other file imports this package.
package ffca_pkg;

	// Default number of blocks the free map can hold.
	localparam int DEF_BLOCKS = 128;

	// Width of one free map word and the matching shift.
	localparam int WORD_W   = 16;
	localparam int LOG_WORD = 4;

	// Block numbers, lengths and the block count all fit in eight bits.
	localparam int BLK_W  = 8;
	// Word base addresses can step one word past the count.
	localparam int BASE_W = BLK_W + 1;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_NOSPACE = 2'd1;
	localparam status_t ST_INVALID = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result of scanning one free map word for the first long enough run.
	typedef struct packed {
		logic             hit;
		logic [BLK_W-1:0] found;
		logic [BLK_W-1:0] carry;
	} scan_res_t;

endpackage

[sv/ffca_map_mem.sv]
// Free map storage: one synchronous word memory with a registered read port.
// Uses ffca_pkg. Per-word valid bits make unwritten words read as all free.
module ffca_map_mem import ffca_pkg::*; #(
	parameter int DEPTH = DEF_BLOCKS / WORD_W,
	parameter int AW    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [WORD_W-1:0] rdat_s1;
	logic              rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// A word never written since reset holds only free blocks.
	assign rd_data = rvld_s1 ? rdat_s1 : '1;

endmodule

[sv/ffca_run_scan.sv]
// Evaluates one free map word during an allocate search.
// Uses ffca_pkg. Finds the lowest block where a free run reaches the length.
module ffca_run_scan import ffca_pkg::*; (
	input  logic [WORD_W-1:0] word,
	input  logic [BASE_W-1:0] base,
	input  logic [BLK_W-1:0]  carry,
	input  logic [BLK_W-1:0]  len,
	input  logic [BLK_W-1:0]  cnt,
	output scan_res_t         res
);

	always_comb begin
		logic [LOG_WORD:0]   lz;
		logic [BASE_W-1:0]   run;
		logic [BASE_W-1:0]   last_run;
		logic [WORD_W-1:0]   hit_vec;
		logic [LOG_WORD-1:0] pos;
		logic [BASE_W-1:0]   found;
		last_run = '0;
		hit_vec  = '0;
		// Each bit position works out independently how long the free run
		// ending there is, from the highest used block at or below it.
		for (int j = 0; j < WORD_W; j++) begin
			lz = '0;
			for (int k = 0; k < WORD_W; k++) begin
				if (k <= j && !word[k]) begin
					lz = (LOG_WORD+1)'(k + 1);
				end
			end
			if (lz == '0) begin
				run = BASE_W'(carry) + BASE_W'(j + 1);
			end else begin
				run = BASE_W'(j + 1) - BASE_W'(lz);
			end
			hit_vec[j] = ((base + BASE_W'(j)) < BASE_W'(cnt)) && (run >= BASE_W'(len));
			if (j == WORD_W - 1) begin
				last_run = run;
			end
		end
		pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				pos = LOG_WORD'(j);
			end
		end
		found     = base + BASE_W'(pos) + BASE_W'(1) - BASE_W'(len);
		res.hit   = |hit_vec;
		res.found = found[BLK_W-1:0];
		res.carry = last_run[BLK_W-1:0];
	end

endmodule

[sv/first_fit_contiguous_block_allocator.sv]
// First-fit contiguous block allocator over a bitmap of free blocks.
// Request channel: req_valid/req_stall with cmd, run_start, run_length.
// Result channel: rsp_valid/rsp_stall with status and alloc_start, one
// result item for every request item, in order.
// The user must write block_count through the APB port only while the
// block is idle; the block itself does not check this. An allocate reads
// the free map 16 blocks per cycle, one word per cycle through the memory
// read port, until the first long enough run is found, then clears that
// run with a read and then a write of each word touched. A free request
// does the same read and write sweep over its run.
// One request is worked on at a time; the next one is taken as soon as
// the result sits in the output register, even while it waits there.
// When the receiver stalls, a second result holds the block until the
// first one leaves. After reset every block is free and block_count is 128.
module first_fit_contiguous_block_allocator import ffca_pkg::*; #(
	parameter int BLOCKS = DEF_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [6:0]  run_start,
	input  logic [7:0]  run_length,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [6:0]  alloc_start
);

	localparam int DEPTH = (BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRD, S_WWR, S_DONE} state_t;

	state_t            state_q;
	logic [BLK_W-1:0]  block_count_q;
	logic [BLK_W-1:0]  cnt;
	logic              op_q;
	logic [BLK_W-1:0]  len_q;
	logic [BLK_W-1:0]  lo_q;
	logic [BLK_W-1:0]  hi_q;
	logic [BASE_W-1:0] cur_base_q;
	logic [BASE_W-1:0] rd_base_q;
	logic [BASE_W-1:0] base_s1;
	logic              v_s1;
	logic [BLK_W-1:0]  carry_q;
	status_t           res_status_q;
	logic [6:0]        res_start_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [6:0]        out_start_q;

	logic              accept;
	logic              issue;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] wmask;
	scan_res_t         scan;
	logic              req_ok;
	logic [BASE_W-1:0] free_end;
	logic              out_free;

	// APB register file: a single register, so every address selects it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= BLK_W'(128);
		end else if (psel && penable && pwrite && pready) begin
			block_count_q <= pwdata[BLK_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0 || paddr != 2'd0) ? {24'd0, block_count_q} : 32'd0;

	assign cnt = (32'(block_count_q) > 32'(BLOCKS)) ? BLK_W'(BLOCKS) : block_count_q;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	assign free_end = BASE_W'(run_start) + BASE_W'(run_length);
	always_comb begin
		if (cmd == CMD_ALLOC) begin
			req_ok = (run_length != '0) && (run_length <= cnt);
		end else begin
			req_ok = (run_length != '0) && (free_end <= BASE_W'(cnt));
		end
	end

	// The search issues a read every cycle while words remain below the
	// block count; no further read is issued once a hit is seen.
	assign issue   = (state_q == S_SCAN) && (rd_base_q < BASE_W'(cnt)) && !(v_s1 && scan.hit);
	assign rd_en   = issue || (state_q == S_WRD);
	assign rd_addr = issue ? AW'(rd_base_q >> LOG_WORD) : AW'(cur_base_q >> LOG_WORD);
	assign wr_en   = (state_q == S_WWR);

	always_comb begin
		logic [BASE_W-1:0] blk;
		for (int j = 0; j < WORD_W; j++) begin
			blk      = cur_base_q + BASE_W'(j);
			wmask[j] = (blk >= BASE_W'(lo_q)) && (blk <= BASE_W'(hi_q));
		end
	end

	assign wr_data = (op_q == CMD_FREE) ? (rd_data | wmask) : (rd_data & ~wmask);

	ffca_map_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.wr_en  (wr_en),
		.wr_addr(AW'(cur_base_q >> LOG_WORD)),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	ffca_run_scan u_scan (
		.word (rd_data),
		.base (base_s1),
		.carry(carry_q),
		.len  (len_q),
		.cnt  (cnt),
		.res  (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
			op_q         <= CMD_ALLOC;
			len_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			cur_base_q   <= '0;
			rd_base_q    <= '0;
			base_s1      <= '0;
			carry_q      <= '0;
			res_status_q <= ST_OK;
			res_start_q  <= '0;
			out_status_q <= ST_OK;
			out_start_q  <= '0;
		end else begin
			v_s1 <= issue;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q        <= cmd;
						len_q       <= run_length;
						res_start_q <= '0;
						if (!req_ok) begin
							res_status_q <= ST_INVALID;
							state_q      <= S_DONE;
						end else if (cmd == CMD_ALLOC) begin
							rd_base_q <= '0;
							carry_q   <= '0;
							state_q   <= S_SCAN;
						end else begin
							lo_q         <= BLK_W'(run_start);
							hi_q         <= free_end[BLK_W-1:0] - BLK_W'(1);
							cur_base_q   <= BASE_W'({run_start[6:LOG_WORD], LOG_WORD'(0)});
							res_status_q <= ST_OK;
							state_q      <= S_WRD;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_base_q <= rd_base_q + BASE_W'(WORD_W);
						base_s1   <= rd_base_q;
					end
					if (v_s1) begin
						if (scan.hit) begin
							lo_q         <= scan.found;
							hi_q         <= scan.found + len_q - BLK_W'(1);
							cur_base_q   <= BASE_W'({scan.found[BLK_W-1:LOG_WORD],
								LOG_WORD'(0)});
							res_status_q <= ST_OK;
							res_start_q  <= scan.found[6:0];
							state_q      <= S_WRD;
						end else if ((base_s1 + BASE_W'(WORD_W)) >= BASE_W'(cnt)) begin
							res_status_q <= ST_NOSPACE;
							state_q      <= S_DONE;
						end else begin
							carry_q <= scan.carry;
						end
					end
				end
				S_WRD: begin
					state_q <= S_WWR;
				end
				S_WWR: begin
					// The next word is read only after this write, so no
					// read ever overlaps a pending write to the same word.
					if ((cur_base_q + BASE_W'(WORD_W)) > BASE_W'(hi_q)) begin
						state_q <= S_DONE;
					end else begin
						cur_base_q <= cur_base_q + BASE_W'(WORD_W);
						state_q    <= S_WRD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = out_valid_q;
	assign status      = out_status_q;
	assign alloc_start = out_start_q;

endmodule

[bench/first_fit_contiguous_block_allocator_tb.sv]
// Self-checking testbench for the first-fit contiguous block allocator.
// Needs ffca_pkg and the allocator RTL; predicts each result from its own copy of
// the free map and block count or a directed row, and compares them in order.
`timescale 1ns / 1ps

module first_fit_contiguous_block_allocator_tb;
	import ffca_pkg::*;

	localparam int BLOCKS = DEF_BLOCKS;
	localparam logic [1:0] REG_BLOCK_COUNT = 2'd0;
	localparam int N_DIRECTED = 21;
	localparam int N_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int PRESSURE_PHASE = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic       op;
		logic [6:0] first;
		logic [7:0] len;
	} blk_req_t;

	typedef struct packed {
		status_t    st;
		logic [6:0] start;
	} alloc_result_t;

	typedef struct packed {
		logic       op;
		logic [6:0] first;
		logic [7:0] len;
		logic       fixed;
		status_t    st;
		logic [6:0] start;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	logic        cmd;
	logic [6:0]  run_start;
	logic [7:0]  run_length;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [1:0]  status;
	logic [6:0]  alloc_start;

	// Predictor state.
	logic [BLOCKS-1:0] free_map;
	logic [7:0]        blk_count;

	alloc_result_t outstanding[$];
	blk_req_t      live_runs[$];
	dir_row_t      dir_rows[N_DIRECTED];

	int fail_count;
	int status_seen[3];
	int snd_idle_pct;
	int rcv_idle_pct;
	bit hold_go;

	first_fit_contiguous_block_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.cmd        (cmd),
		.run_start  (run_start),
		.run_length (run_length),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.alloc_start(alloc_start)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic alloc_result_t apply_request(input blk_req_t rq);
		alloc_result_t r;
		int lim;
		int run;
		int pos;
		int i;
		bit hit;
		lim = (blk_count > BLOCKS) ? BLOCKS : int'(blk_count);
		r.st = ST_INVALID;
		r.start = '0;
		run = 0;
		pos = 0;
		hit = 1'b0;
		if (rq.op == CMD_ALLOC) begin
			if (rq.len != 0 && int'(rq.len) <= lim) begin
				// First fit: stop at the first window of len free blocks.
				for (i = 0; i < lim && !hit; i++) begin
					run = free_map[i] ? run + 1 : 0;
					if (run == int'(rq.len)) begin
						hit = 1'b1;
						pos = i + 1 - int'(rq.len);
					end
				end
				if (hit) begin
					for (i = pos; i < pos + int'(rq.len); i++)
						free_map[i] = 1'b0;
					r.st = ST_OK;
					r.start = pos[6:0];
				end else begin
					r.st = ST_NOSPACE;
				end
			end
		end else if (rq.len != 0 && int'(rq.first) + int'(rq.len) <= lim) begin
			for (i = int'(rq.first); i < int'(rq.first) + int'(rq.len); i++)
				free_map[i] = 1'b1;
			r.st = ST_OK;
		end
		return r;
	endfunction

	// Mostly allocations and frees of runs handed out earlier, with some noise.
	function automatic blk_req_t pick_request();
		blk_req_t rq;
		int lim;
		int span;
		int pick;
		int k;
		lim = (blk_count > BLOCKS) ? BLOCKS : int'(blk_count);
		span = (lim > 0) ? lim : 8;
		pick = $urandom_range(99);
		rq.op = CMD_ALLOC;
		rq.first = 7'($urandom_range(127));
		rq.len = 8'($urandom_range(1, (span / 8 > 1) ? span / 8 : 1));
		if (pick < 40 && live_runs.size() > 0) begin
			k = $urandom_range(live_runs.size() - 1);
			rq = live_runs[k];
			live_runs.delete(k);
		end else if (pick < 72) begin
			rq.op = CMD_ALLOC;
		end else if (pick < 84) begin
			rq.len = 8'($urandom_range(1, span));
		end else if (pick < 92) begin
			rq.op = CMD_FREE;
			rq.first = 7'($urandom_range(span - 1));
			rq.len = 8'($urandom_range(1, span - int'(rq.first)));
		end else begin
			rq.op = 1'($urandom_range(1));
			rq.len = 8'($urandom_range(128));
		end
		return rq;
	endfunction

	task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_BLOCK_COUNT)
			blk_count = data[7:0];
	endtask

	// Valid is left high after acceptance so that a back-to-back item
	// only changes the payload.
	task automatic offer_request(input blk_req_t rq, input bit fixed,
			input alloc_result_t want);
		alloc_result_t got;
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		cmd <= rq.op;
		run_start <= rq.first;
		run_length <= rq.len;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		got = apply_request(rq);
		if (rq.op == CMD_ALLOC && got.st == ST_OK)
			live_runs.push_back('{CMD_FREE, got.start, rq.len});
		status_seen[got.st]++;
		outstanding.push_back(fixed ? want : got);
	endtask

	task automatic wait_drained();
		while (outstanding.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin : rsp_check
		alloc_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (outstanding.size() == 0) begin
				$display("%0t: unexpected result, expected none, got status %0d start %0d",
					$time, status, alloc_start);
				fail_count++;
			end else begin
				want = outstanding.pop_front();
				if (status !== want.st) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.st, status);
					fail_count++;
				end
				if (alloc_start !== want.start) begin
					$display("%0t: alloc_start mismatch, expected %0d, got %0d",
						$time, want.start, alloc_start);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, or one long hold-off counted here.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		logic [7:0] phase_count[N_PHASES];
		blk_req_t rq;
		alloc_result_t want;
		int ph;
		int n;
		phase_count = '{8'd128, 8'd1, 8'd64, 8'd0, 8'd255, 8'd16, 8'd100, 8'd128,
			8'd8, 8'd128};
		dir_rows = '{
			'{CMD_ALLOC, 7'd0,   8'd0,   1'b1, ST_INVALID, 7'd0},
			'{CMD_FREE,  7'd0,   8'd0,   1'b1, ST_INVALID, 7'd0},
			'{CMD_FREE,  7'd127, 8'd2,   1'b1, ST_INVALID, 7'd0},
			'{CMD_ALLOC, 7'd127, 8'd128, 1'b1, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd1,   1'b1, ST_NOSPACE, 7'd0},
			'{CMD_FREE,  7'd0,   8'd128, 1'b1, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd85,  8'd1,   1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd3,   1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd1,   8'd1,   1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd42,  8'd2,   1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd1,   1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd100, 8'd10,  1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd127, 8'd1,   1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd122, 1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd1,   1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd64,  8'd64,  1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd64,  1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd0,   8'd128, 1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd0,   8'd128, 1'b0, ST_OK,      7'd0},
			'{CMD_ALLOC, 7'd127, 8'd127, 1'b0, ST_OK,      7'd0},
			'{CMD_FREE,  7'd127, 8'd128, 1'b1, ST_INVALID, 7'd0}
		};
		fail_count = 0;
		status_seen = '{0, 0, 0};
		hold_go = 1'b0;
		snd_idle_pct = 21;
		rcv_idle_pct = 74;
		free_map = '1;
		blk_count = 8'd128;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		cmd <= CMD_ALLOC;
		run_start <= '0;
		run_length <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < N_DIRECTED; n++) begin
			rq = '{dir_rows[n].op, dir_rows[n].first, dir_rows[n].len};
			want = '{dir_rows[n].st, dir_rows[n].start};
			offer_request(rq, dir_rows[n].fixed, want);
		end
		req_valid <= 1'b0;
		wait_drained();

		for (ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 4) begin
				snd_idle_pct = 21;
				rcv_idle_pct = 74;
			end else if (ph < PRESSURE_PHASE) begin
				snd_idle_pct = 74;
				rcv_idle_pct = 21;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			apb_write(REG_BLOCK_COUNT, {24'd0, phase_count[ph]});
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == PRESSURE_PHASE && n == 20)
					hold_go = 1'b1;
				// Let every result of the pressure burst come home before
				// the sender goes on.
				if (ph == PRESSURE_PHASE && n == 60) begin
					req_valid <= 1'b0;
					wait_drained();
				end
				offer_request(pick_request(), 1'b0, '0);
			end
			req_valid <= 1'b0;
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d requests over %0d block-count settings, 0 and 255 included.",
			N_DIRECTED + N_PHASES * ITEMS_PER_PHASE, N_PHASES);
		$display("Results: %0d successful, %0d without space, %0d invalid.",
			status_seen[ST_OK], status_seen[ST_NOSPACE], status_seen[ST_INVALID]);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

[first_fit_contiguous_block_allocator.f]
sv/ffca_pkg.sv
sv/ffca_map_mem.sv
sv/ffca_run_scan.sv
sv/first_fit_contiguous_block_allocator.sv
bench/first_fit_contiguous_block_allocator_tb.sv
